>>> sv/rsvj_pkg.sv
// Package for the RTP sequence check and jitter block.
// Holds field widths, register codes, reset values, record types and the divider step.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package rsvj_pkg;

  localparam int SeqW      = 16;
  localparam int TsW       = 32;
  localparam int ArrW      = 48;
  localparam int SizeW     = 16;
  localparam int JitW      = 36;
  localparam int ExtW      = 32;
  localparam int PktW      = 32;
  localparam int ByteW     = 40;
  localparam int ProbW     = 8;
  localparam int RateW     = 20;
  localparam int BadW      = 17;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 20;

  localparam logic [CfgIdxW-1:0] CfgProbation = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDropout   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMisorder  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgClockRate = 2'd3;

  localparam logic [ProbW-1:0] ProbationRst = 8'd2;
  localparam logic [SeqW-1:0]  DropoutRst   = 16'd3000;
  localparam logic [SeqW-1:0]  MisorderRst  = 16'd100;
  localparam logic [RateW-1:0] ClockRateRst = 20'd90000;

  localparam logic [BadW-1:0]  BadNone  = 17'h10001;
  localparam logic [BadW-1:0]  SeqSpan  = 17'h10000;
  localparam logic [RateW-1:0] UsPerS   = 20'd1000000;

  // Divider pipeline layout: quotient bits per stage and stage positions.
  localparam int DivBits    = 4;
  localparam int DivAStages = 8;
  localparam int DivBStages = 5;
  localparam int DivBPad    = 32 - DivBStages * DivBits;
  localparam int MulStage   = DivAStages;
  localparam int DiffStage  = DivAStages + 1 + DivBStages;
  localparam int PipeDepth  = DiffStage + 1;

  localparam int FifoDepth  = 4;
  localparam int FifoPtrW   = 2;

  typedef enum logic [1:0] {
    JitKeep,
    JitClear,
    JitUpdate
  } jit_op_e;

  typedef struct packed {
    logic [ProbW-1:0] probation;
    logic [SeqW-1:0]  dropout;
    logic [SeqW-1:0]  misorder;
    logic [RateW-1:0] clock_rate;
  } rsvj_cfg_t;

  typedef struct packed {
    logic             accepted;
    jit_op_e          op;
    logic [ArrW-1:0]  elapsed;
    logic [TsW-1:0]   t_diff;
    logic [ExtW-1:0]  ext_seq;
    logic [PktW-1:0]  packets;
    logic [ByteW-1:0] bytes;
  } rsvj_rec_t;

  typedef struct packed {
    logic             accepted;
    jit_op_e          op;
    logic [ExtW-1:0]  ext_seq;
    logic [PktW-1:0]  packets;
    logic [ByteW-1:0] bytes;
    logic [TsW-1:0]   t_diff;
    logic [31:0]      e_part;
    logic [19:0]      rem;
    logic [31:0]      dq;
  } rsvj_pipe_t;

  // Restoring division by one million, DivBits quotient bits per call.
  function automatic rsvj_pipe_t div_step(input rsvj_pipe_t p);
    rsvj_pipe_t  r;
    logic [20:0] rem_w;
    r = p;
    for (int i = 0; i < DivBits; i++) begin
      rem_w = {r.rem, r.dq[31]};
      r.dq  = {r.dq[30:0], 1'b0};
      if (rem_w >= {1'b0, UsPerS}) begin
        rem_w   = rem_w - {1'b0, UsPerS};
        r.dq[0] = 1'b1;
      end
      r.rem = rem_w[19:0];
    end
    return r;
  endfunction

endpackage

>>> sv/rsvj_in_if.sv
// Input channel carrying one received packet item.
// Depends on rsvj_pkg for the field widths.
`timescale 1ns / 1ps

interface rsvj_in_if import rsvj_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SeqW-1:0]  sequence_number;
  logic [TsW-1:0]   rtp_timestamp;
  logic [ArrW-1:0]  arrival_us;
  logic [SizeW-1:0] packet_size;

  modport source (output valid, output sequence_number, output rtp_timestamp,
                  output arrival_us, output packet_size, input ready);
  modport sink (input valid, input sequence_number, input rtp_timestamp,
                input arrival_us, input packet_size, output ready);
endinterface

>>> sv/rsvj_out_if.sv
// Output channel carrying one result item per packet.
// Depends on rsvj_pkg for the field widths.
`timescale 1ns / 1ps

interface rsvj_out_if import rsvj_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             accepted;
  logic [JitW-1:0]  jitter_q4;
  logic [ExtW-1:0]  extended_highest_seq;
  logic [PktW-1:0]  packets_received;
  logic [ByteW-1:0] bytes_received;

  modport source (output valid, output accepted, output jitter_q4,
                  output extended_highest_seq, output packets_received,
                  output bytes_received, input ready);
  modport sink (input valid, input accepted, input jitter_q4,
                input extended_highest_seq, input packets_received,
                input bytes_received, output ready);
endinterface

>>> sv/rtp_seq_validate_jitter.sv
// RTP sequence validation and interarrival jitter, one result item per packet item.
// Each item passes one queue write, fifteen pipeline stages (32-bit and 20-bit divisions by one
// million, four quotient bits a stage) and the output register, where jitter accumulates.
// Throughput is one item per cycle unless out_o.ready stalls the output.
// Reset restores register defaults, clears sequence state, counters and jitter, and empties
// the queue and pipeline at once; there is no clearing pass.
`timescale 1ns / 1ps

module rtp_seq_validate_jitter import rsvj_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  rsvj_in_if.sink             in_i,
  rsvj_out_if.source          out_o
);

  rsvj_cfg_t cfg_q;
  rsvj_rec_t rec, head;
  logic      push, pop, empty, full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.probation  <= ProbationRst;
      cfg_q.dropout    <= DropoutRst;
      cfg_q.misorder   <= MisorderRst;
      cfg_q.clock_rate <= ClockRateRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgProbation: cfg_q.probation  <= cfg_data_i[ProbW-1:0];
        CfgDropout:   cfg_q.dropout    <= cfg_data_i[SeqW-1:0];
        CfgMisorder:  cfg_q.misorder   <= cfg_data_i[SeqW-1:0];
        CfgClockRate: cfg_q.clock_rate <= cfg_data_i[RateW-1:0];
        default:      cfg_q            <= cfg_q;
      endcase
    end
  end

  rsvj_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .rec_o  (rec)
  );

  rsvj_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  rsvj_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rate_i  (cfg_q.clock_rate),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

>>> sv/rsvj_front.sv
// Front end: sequence validation, probation and counters for each accepted item.
// Depends on rsvj_pkg and rsvj_in_if; pushes a classified record into the queue.
`timescale 1ns / 1ps

module rsvj_front import rsvj_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  rsvj_cfg_t  cfg_i,
  rsvj_in_if.sink    in_i,
  input  logic       full_i,
  output logic       push_o,
  output rsvj_rec_t  rec_o
);

  logic             started_q, started_d;
  logic [SeqW-1:0]  high_q, high_d;
  logic [BadW-1:0]  bad_q, bad_d;
  logic [SeqW-1:0]  wrap_q, wrap_d;
  logic [ProbW-1:0] prob_q, prob_d;
  logic [PktW-1:0]  pkt_q, pkt_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic [ArrW-1:0]  arr_q, arr_d;
  logic [TsW-1:0]   ts_q, ts_d;

  logic [SeqW-1:0]  seq;
  logic [SeqW-1:0]  delta;
  logic             ok;
  logic             clr;
  logic             chk;
  jit_op_e          op;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;
  assign seq        = in_i.sequence_number;

  always_comb begin
    started_d = started_q;
    high_d    = high_q;
    bad_d     = bad_q;
    wrap_d    = wrap_q;
    prob_d    = prob_q;
    pkt_d     = pkt_q;
    byte_d    = byte_q;
    arr_d     = arr_q;
    ts_d      = ts_q;
    ok        = 1'b0;
    clr       = 1'b0;
    chk       = 1'b1;
    op        = JitKeep;

    if (!started_q) begin
      started_d = 1'b1;
      high_d    = seq;
      bad_d     = BadNone;
      wrap_d    = '0;
      pkt_d     = '0;
      byte_d    = '0;
      prob_d    = '0;
      clr       = 1'b1;
      if (cfg_i.probation == '0) begin
        ok  = 1'b1;
        chk = 1'b0;
      end else begin
        high_d = seq - 16'd1;
        prob_d = cfg_i.probation;
      end
    end

    delta = seq - high_d;

    if (chk) begin
      if (prob_d != '0) begin
        if (seq == high_d + 16'd1) begin
          high_d = seq;
          prob_d = prob_d - 8'd1;
          if (prob_d == '0) begin
            bad_d  = BadNone;
            wrap_d = '0;
            pkt_d  = '0;
            byte_d = '0;
            clr    = 1'b1;
            ok     = 1'b1;
          end
        end else begin
          prob_d = (cfg_i.probation != '0) ? cfg_i.probation - 8'd1 : '0;
          high_d = seq;
        end
      end else if ({1'b0, delta} < {1'b0, cfg_i.dropout}) begin
        if (seq < high_d) begin
          wrap_d = wrap_d + 16'd1;
        end
        high_d = seq;
        ok     = 1'b1;
      end else if ({1'b0, delta} <= SeqSpan - {1'b0, cfg_i.misorder}) begin
        if ({1'b0, seq} == bad_d) begin
          high_d = seq;
          bad_d  = BadNone;
          wrap_d = '0;
          pkt_d  = '0;
          byte_d = '0;
          prob_d = '0;
          clr    = 1'b1;
          ok     = 1'b1;
        end else begin
          bad_d = {1'b0, seq + 16'd1};
        end
      end else begin
        ok = 1'b1;
      end
    end

    if (ok) begin
      op     = (pkt_d != '0) ? JitUpdate : JitClear;
      arr_d  = in_i.arrival_us;
      ts_d   = in_i.rtp_timestamp;
      byte_d = byte_d + {{(ByteW-SizeW){1'b0}}, in_i.packet_size};
      pkt_d  = pkt_d + 32'd1;
    end else if (clr) begin
      op = JitClear;
    end
  end

  always_comb begin
    rec_o.accepted = ok;
    rec_o.op       = op;
    rec_o.elapsed  = in_i.arrival_us - arr_q;
    rec_o.t_diff   = in_i.rtp_timestamp - ts_q;
    rec_o.ext_seq  = {wrap_d, high_d};
    rec_o.packets  = pkt_d;
    rec_o.bytes    = byte_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      high_q    <= '0;
      bad_q     <= BadNone;
      wrap_q    <= '0;
      prob_q    <= '0;
      pkt_q     <= '0;
      byte_q    <= '0;
      arr_q     <= '0;
      ts_q      <= '0;
    end else if (push_o) begin
      started_q <= started_d;
      high_q    <= high_d;
      bad_q     <= bad_d;
      wrap_q    <= wrap_d;
      prob_q    <= prob_d;
      pkt_q     <= pkt_d;
      byte_q    <= byte_d;
      arr_q     <= arr_d;
      ts_q      <= ts_d;
    end
  end

endmodule

>>> sv/rsvj_fifo.sv
// Short queue of classified records between the front end and the jitter pipeline.
// Depends on rsvj_pkg for the record type and depth.
`timescale 1ns / 1ps

module rsvj_fifo import rsvj_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  rsvj_rec_t rec_i,
  input  logic      pop_i,
  output rsvj_rec_t head_o,
  output logic      empty_o,
  output logic      full_o
);

  rsvj_rec_t           mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, rd_q;
  logic [FifoPtrW:0]   cnt_q;
  logic                do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (FifoPtrW+1)'(FifoDepth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= rec_i;
    end
  end

endmodule

>>> sv/rsvj_back.sv
// Back end: scales elapsed arrival time, forms the transit difference and updates jitter.
// Depends on rsvj_pkg and rsvj_out_if; pops records from the queue.
`timescale 1ns / 1ps

module rsvj_back import rsvj_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [RateW-1:0] rate_i,
  input  rsvj_rec_t        head_i,
  input  logic             empty_i,
  output logic             pop_o,
  rsvj_out_if.source       out_o
);

  rsvj_pipe_t           head;
  rsvj_pipe_t           pipe_q [PipeDepth];
  rsvj_pipe_t           pipe_d [PipeDepth];
  logic [PipeDepth-1:0] vld_q;
  logic                 adv;

  logic                 out_vld_q;
  logic                 out_acc_q;
  logic [ExtW-1:0]      out_ext_q;
  logic [PktW-1:0]      out_pkt_q;
  logic [ByteW-1:0]     out_byte_q;
  logic [JitW-1:0]      acc_q, acc_d;
  logic [JitW:0]        acc_ext, acc_dec, acc_sum;
  rsvj_pipe_t           last;

  assign adv   = !out_vld_q || out_o.ready;
  assign pop_o = adv && !empty_i;

  always_comb begin
    head.accepted = head_i.accepted;
    head.op       = head_i.op;
    head.ext_seq  = head_i.ext_seq;
    head.packets  = head_i.packets;
    head.bytes    = head_i.bytes;
    head.t_diff   = head_i.t_diff;
    head.e_part   = '0;
    head.rem      = {4'b0, head_i.elapsed[47:32]};
    head.dq       = head_i.elapsed[31:0];
  end

  for (genvar s = 0; s < PipeDepth; s++) begin : g_stage
    rsvj_pipe_t prev;
    logic       prev_vld;

    if (s == 0) begin : g_head
      assign prev     = head;
      assign prev_vld = !empty_i;
    end else begin : g_link
      assign prev     = pipe_q[s-1];
      assign prev_vld = vld_q[s-1];
    end

    if (s == MulStage) begin : g_mul
      logic [51:0] prod_a;
      logic [39:0] prod_b;
      assign prod_a = {20'b0, prev.dq} * {32'b0, rate_i};
      assign prod_b = {20'b0, prev.rem} * {20'b0, rate_i};
      always_comb begin
        pipe_d[s]        = prev;
        pipe_d[s].e_part = prod_a[31:0];
        pipe_d[s].rem    = prod_b[39:20];
        pipe_d[s].dq     = {prod_b[19:0], {DivBPad{1'b0}}};
      end
    end else if (s == DiffStage) begin : g_diff
      logic [31:0] e_sum, x_val;
      assign e_sum = prev.e_part + {12'b0, prev.dq[19:0]};
      assign x_val = e_sum - prev.t_diff;
      always_comb begin
        pipe_d[s]        = prev;
        pipe_d[s].e_part = x_val[31] ? (~x_val + 32'd1) : x_val;
      end
    end else begin : g_div
      assign pipe_d[s] = div_step(prev);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (adv) begin
        vld_q[s] <= prev_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        pipe_q[s] <= pipe_d[s];
      end
    end
  end

  assign last    = pipe_q[PipeDepth-1];
  assign acc_ext = {1'b0, acc_q};
  assign acc_dec = (acc_ext + 37'd8) >> 4;
  assign acc_sum = acc_ext + {5'b0, last.e_part} - acc_dec;

  always_comb begin
    unique case (last.op)
      JitKeep:   acc_d = acc_q;
      JitClear:  acc_d = '0;
      JitUpdate: acc_d = acc_sum[JitW] ? '1 : acc_sum[JitW-1:0];
      default:   acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      acc_q     <= '0;
    end else if (adv) begin
      out_vld_q <= vld_q[PipeDepth-1];
      if (vld_q[PipeDepth-1]) begin
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && vld_q[PipeDepth-1]) begin
      out_acc_q  <= last.accepted;
      out_ext_q  <= last.ext_seq;
      out_pkt_q  <= last.packets;
      out_byte_q <= last.bytes;
    end
  end

  assign out_o.valid                = out_vld_q;
  assign out_o.accepted             = out_acc_q;
  assign out_o.jitter_q4            = acc_q;
  assign out_o.extended_highest_seq = out_ext_q;
  assign out_o.packets_received     = out_pkt_q;
  assign out_o.bytes_received       = out_byte_q;

endmodule
